FILE: sv/sav_pkg.sv
// shared constants, types and helpers for the six-axis moving average core
// no dependencies
package sav_pkg;

    localparam int MaxWindow   = 64;
    localparam int SampleBits  = 16;
    localparam int Axes        = 6;
    localparam int WindowBits  = 7;
    localparam int WindowReset = 10;
    localparam int SlotBits    = $clog2(MaxWindow);
    localparam int CountBits   = $clog2(MaxWindow + 1);
    localparam int SumBits     = SampleBits + $clog2(MaxWindow);
    localparam int StepBits    = $clog2(SumBits);

    typedef logic signed [SampleBits-1:0] sample_t;
    typedef logic signed [SumBits-1:0]    sum_t;

    typedef struct packed {
        logic                 clear;
        logic                 load;
        logic [SlotBits-1:0]  slot;
        logic                 accum;
        logic                 subtract;
        logic                 step;
        logic [CountBits-1:0] divisor;
    } lane_ctl_t;

    function automatic logic [CountBits-1:0] eff_window(input logic [WindowBits-1:0] wl);
        logic [CountBits-1:0] w;
        begin
            w = CountBits'(wl);
            if (wl == '0)
                w = CountBits'(1);
            else if (CountBits'(wl) > CountBits'(MaxWindow))
                w = CountBits'(MaxWindow);
            return w;
        end
    endfunction

endpackage

FILE: sv/six_axis_moving_average_core.sv
// each sample passes the accumulate state, the 22-step serial divider in each lane and the hold
// state, which waits for the output register to be free; no new sample is taken until it is published
// the next sample is taken while the previous result waits in the output register
// reset (rst_n, async, active low) empties the window and sets its length to 10
// a window length write also empties the window
module six_axis_moving_average_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sav_pkg::WindowBits-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sav_pkg::sample_t               accel_x,
    input  sav_pkg::sample_t               accel_y,
    input  sav_pkg::sample_t               accel_z,
    input  sav_pkg::sample_t               gyro_x,
    input  sav_pkg::sample_t               gyro_y,
    input  sav_pkg::sample_t               gyro_z,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sav_pkg::sample_t               mean_accel_x,
    output sav_pkg::sample_t               mean_accel_y,
    output sav_pkg::sample_t               mean_accel_z,
    output sav_pkg::sample_t               mean_gyro_x,
    output sav_pkg::sample_t               mean_gyro_y,
    output sav_pkg::sample_t               mean_gyro_z
);

    sav_pkg::lane_ctl_t ctl;
    logic               publish;
    logic               out_valid_reg, out_valid_next;

    sav_pkg::sample_t lane_in   [sav_pkg::Axes];
    sav_pkg::sample_t lane_mean [sav_pkg::Axes];
    sav_pkg::sample_t mean_reg  [sav_pkg::Axes];

    assign lane_in[0] = accel_x;
    assign lane_in[1] = accel_y;
    assign lane_in[2] = accel_z;
    assign lane_in[3] = gyro_x;
    assign lane_in[4] = gyro_y;
    assign lane_in[5] = gyro_z;

    sav_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid_reg),
        .out_ready (out_ready),
        .publish   (publish),
        .ctl       (ctl)
    );

    for (genvar i = 0; i < sav_pkg::Axes; i++)
    begin : g_lane
        sav_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .sample (lane_in[i]),
            .mean   (lane_mean[i])
        );
    end

    // merge stage: all lanes finish together and load one output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (publish)
            mean_reg <= lane_mean;
    end

    assign out_valid    = out_valid_reg;
    assign mean_accel_x = mean_reg[0];
    assign mean_accel_y = mean_reg[1];
    assign mean_accel_z = mean_reg[2];
    assign mean_gyro_x  = mean_reg[3];
    assign mean_gyro_y  = mean_reg[4];
    assign mean_gyro_z  = mean_reg[5];

endmodule

FILE: sv/sav_lane.sv
// one channel lane: history ring, running sum and serial restoring divider
// depends on sav_pkg
module sav_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  sav_pkg::lane_ctl_t  ctl,
    input  sav_pkg::sample_t    sample,
    output sav_pkg::sample_t    mean
);

    sav_pkg::sample_t hist_mem [sav_pkg::MaxWindow];

    sav_pkg::sample_t old_reg;
    sav_pkg::sample_t sample_reg;
    sav_pkg::sum_t    sum_reg, sum_next;

    logic [sav_pkg::SumBits-1:0]   dq_reg, dq_next;
    logic [sav_pkg::CountBits-1:0] rem_reg, rem_next;
    logic                          neg_reg, neg_next;

    logic [sav_pkg::CountBits:0]   rem_shift;
    logic [sav_pkg::SumBits-1:0]   sum_mag;
    logic [sav_pkg::SumBits-1:0]   quo_signed;
    sav_pkg::sum_t                 sum_calc;

    // ring read with old data, write of the new sample
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            old_reg           <= hist_mem[ctl.slot];
            hist_mem[ctl.slot] <= sample;
            sample_reg        <= sample;
        end
    end

    always_comb
    begin
        sum_calc = sum_reg + sav_pkg::SumBits'(sample_reg);
        if (ctl.subtract)
            sum_calc = sum_calc - sav_pkg::SumBits'(old_reg);
        sum_mag   = sum_calc[sav_pkg::SumBits-1] ? (~sum_calc + 1'b1) : sum_calc;
        rem_shift = {rem_reg, dq_reg[sav_pkg::SumBits-1]};

        sum_next = sum_reg;
        dq_next  = dq_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;

        if (ctl.clear)
        begin
            sum_next = '0;
        end
        else if (ctl.accum)
        begin
            sum_next = sum_calc;
            dq_next  = sum_mag;
            rem_next = '0;
            neg_next = sum_calc[sav_pkg::SumBits-1];
        end
        else if (ctl.step)
        begin
            if (rem_shift >= {1'b0, ctl.divisor})
            begin
                rem_next = sav_pkg::CountBits'(rem_shift - {1'b0, ctl.divisor});
                dq_next  = {dq_reg[sav_pkg::SumBits-2:0], 1'b1};
            end
            else
            begin
                rem_next = sav_pkg::CountBits'(rem_shift);
                dq_next  = {dq_reg[sav_pkg::SumBits-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign quo_signed = neg_reg ? (~dq_reg + 1'b1) : dq_reg;
    assign mean       = quo_signed[sav_pkg::SampleBits-1:0];

endmodule

FILE: sv/sav_ctrl.sv
// sequencer shared by all lanes: window register, fill count, ring slot, divide steps
// depends on sav_pkg
module sav_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sav_pkg::WindowBits-1:0]   cfg_data,
    input  logic                             out_valid,
    input  logic                             out_ready,
    output logic                             publish,
    output sav_pkg::lane_ctl_t               ctl
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ACCUM  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_HOLD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [sav_pkg::WindowBits-1:0] window_reg, window_next;
    logic [sav_pkg::CountBits-1:0]  fill_reg, fill_next;
    logic [sav_pkg::SlotBits-1:0]   slot_reg, slot_next;
    logic                           sub_reg, sub_next;
    logic [sav_pkg::StepBits-1:0]   step_reg, step_next;

    logic                           cfg_fire;
    logic                           in_fire;
    logic [sav_pkg::CountBits-1:0]  win_len;
    logic [sav_pkg::CountBits-1:0]  slot_inc;

    // window writes only between samples, and they win over a new sample
    assign cfg_ready = (state_reg == ST_IDLE);
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_ready  = (state_reg == ST_IDLE) & ~cfg_valid;
    assign in_fire   = in_valid & in_ready;
    assign win_len   = sav_pkg::eff_window(window_reg);
    assign slot_inc  = sav_pkg::CountBits'(slot_reg) + sav_pkg::CountBits'(1);
    assign publish   = (state_reg == ST_HOLD) & (~out_valid | out_ready);

    always_comb
    begin
        state_next  = state_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        slot_next   = slot_reg;
        sub_next    = sub_reg;
        step_next   = step_reg;

        if (cfg_fire)
        begin
            window_next = cfg_data;
            fill_next   = '0;
            slot_next   = '0;
        end
        else if (in_fire)
        begin
            sub_next = (fill_reg >= win_len);
            if (fill_reg < win_len)
                fill_next = fill_reg + sav_pkg::CountBits'(1);
            if (slot_inc >= win_len)
                slot_next = '0;
            else
                slot_next = slot_inc[sav_pkg::SlotBits-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                step_next  = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                step_next = step_reg + sav_pkg::StepBits'(1);
                if (step_reg == sav_pkg::StepBits'(sav_pkg::SumBits - 1))
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (publish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            window_reg <= sav_pkg::WindowBits'(sav_pkg::WindowReset);
            fill_reg   <= '0;
            slot_reg   <= '0;
            sub_reg    <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            slot_reg   <= slot_next;
            sub_reg    <= sub_next;
            step_reg   <= step_next;
        end
    end

    always_comb
    begin
        ctl.clear    = cfg_fire;
        ctl.load     = in_fire;
        ctl.slot     = slot_reg;
        ctl.accum    = (state_reg == ST_ACCUM);
        ctl.subtract = sub_reg;
        ctl.step     = (state_reg == ST_DIVIDE);
        ctl.divisor  = fill_reg;
    end

endmodule

FILE: sv/sav_checker.sv
// port-level checks for six_axis_moving_average_core, attached with bind
// depends on sav_pkg and the top level's ports
module sav_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input sav_pkg::sample_t mean_accel_x,
    input sav_pkg::sample_t mean_gyro_z
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean_accel_x)
            && $stable(mean_gyro_z))
        else $error("stalled result changed");

    // one sample in flight at a time
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample is in flight");

    // a result cannot appear right after a transaction
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // input is still closed while the divide runs
    a_busy_span: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##2 !in_ready)
        else $error("input reopened during divide");

endmodule

bind six_axis_moving_average_core sav_checker u_sav_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mean_accel_x (mean_accel_x),
    .mean_gyro_z  (mean_gyro_z)
);

FILE: tb/moving_average_checker.sv
// checker for six_axis_moving_average_core: follows the window, sample and mean channels,
// keeps its own copy of the window state, predicts each mean set and compares it field by field
// depends on sav_pkg
module moving_average_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [sav_pkg::WindowBits-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  sav_pkg::sample_t               accel_x,
    input  sav_pkg::sample_t               accel_y,
    input  sav_pkg::sample_t               accel_z,
    input  sav_pkg::sample_t               gyro_x,
    input  sav_pkg::sample_t               gyro_y,
    input  sav_pkg::sample_t               gyro_z,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  sav_pkg::sample_t               mean_accel_x,
    input  sav_pkg::sample_t               mean_accel_y,
    input  sav_pkg::sample_t               mean_accel_z,
    input  sav_pkg::sample_t               mean_gyro_x,
    input  sav_pkg::sample_t               mean_gyro_y,
    input  sav_pkg::sample_t               mean_gyro_z,
    output int                             mismatch_count,
    output int                             results_owed
);

    localparam int ExpectDepth = 8;

    typedef logic [sav_pkg::Axes-1:0][sav_pkg::SampleBits-1:0] axis_vec_t;

    logic [sav_pkg::WindowBits-1:0] window_reg;
    int                             held;
    int                             next_slot;
    int                             history [sav_pkg::MaxWindow][sav_pkg::Axes];
    longint                         sums [sav_pkg::Axes];
    axis_vec_t                      expected_means [ExpectDepth];
    int                             head_idx;
    int                             tail_idx;

    function automatic string channel_name(input int idx);
        case (idx)
            0: return "mean_accel_x";
            1: return "mean_accel_y";
            2: return "mean_accel_z";
            3: return "mean_gyro_x";
            4: return "mean_gyro_y";
            default: return "mean_gyro_z";
        endcase
    endfunction

    function automatic void empty_window();
        for (int i = 0; i < sav_pkg::Axes; i++)
            sums[i] = 0;
        held = 0;
        next_slot = 0;
    endfunction

    function automatic axis_vec_t advance_window(input axis_vec_t sample);
        int        span;
        longint    quotient;
        axis_vec_t means;
        if (window_reg == '0)
            span = 1;
        else if (int'(window_reg) > sav_pkg::MaxWindow)
            span = sav_pkg::MaxWindow;
        else
            span = int'(window_reg);
        // full window: the oldest sample leaves the running sums
        if (held >= span)
        begin
            for (int i = 0; i < sav_pkg::Axes; i++)
                sums[i] -= history[next_slot][i];
        end
        else
            held++;
        for (int i = 0; i < sav_pkg::Axes; i++)
        begin
            history[next_slot][i] = int'($signed(sample[i]));
            sums[i] += $signed(sample[i]);
        end
        next_slot++;
        if (next_slot >= span)
            next_slot = 0;
        for (int i = 0; i < sav_pkg::Axes; i++)
        begin
            quotient = sums[i] / longint'(held);
            means[i] = quotient[sav_pkg::SampleBits-1:0];
        end
        return means;
    endfunction

    task automatic report(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        axis_vec_t got;
        axis_vec_t want;
        if (!rst_n)
        begin
            window_reg = sav_pkg::WindowBits'(sav_pkg::WindowReset);
            empty_window();
            head_idx = 0;
            tail_idx = 0;
            mismatch_count = 0;
            results_owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {mean_gyro_z, mean_gyro_y, mean_gyro_x,
                       mean_accel_z, mean_accel_y, mean_accel_x};
                if (tail_idx == head_idx)
                    report($sformatf("mean transaction %h with none expected", got));
                else
                begin
                    want = expected_means[head_idx % ExpectDepth];
                    head_idx++;
                    for (int i = 0; i < sav_pkg::Axes; i++)
                        if (got[i] !== want[i])
                            report($sformatf("%s got %0d expected %0d", channel_name(i),
                                             $signed(got[i]), $signed(want[i])));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                window_reg = cfg_data;
                empty_window();
            end
            if (in_valid && in_ready)
            begin
                if (tail_idx - head_idx >= ExpectDepth)
                    report("more sample transactions outstanding than the block can hold");
                else
                begin
                    expected_means[tail_idx % ExpectDepth] =
                        advance_window({gyro_z, gyro_y, gyro_x,
                                        accel_z, accel_y, accel_x});
                    tail_idx++;
                end
            end
            results_owed <= tail_idx - head_idx;
        end
    end

endmodule

FILE: tb/tb.sv
// testbench top for six_axis_moving_average_core: writes window lengths, offers samples
// with random gaps, stalls the mean channel and gives the verdict
// depends on sav_pkg, six_axis_moving_average_core and moving_average_checker
module tb;

    localparam int IdleLimit  = 3000;
    localparam int SampleGoal = 700;
    localparam int LongHold   = 400;
    localparam int HoldAt     = 150;
    localparam int DrainTail  = 40;

    typedef logic [sav_pkg::Axes-1:0][sav_pkg::SampleBits-1:0] axis_vec_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sav_pkg::WindowBits-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    sav_pkg::sample_t               accel_x = '0;
    sav_pkg::sample_t               accel_y = '0;
    sav_pkg::sample_t               accel_z = '0;
    sav_pkg::sample_t               gyro_x = '0;
    sav_pkg::sample_t               gyro_y = '0;
    sav_pkg::sample_t               gyro_z = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    sav_pkg::sample_t               mean_accel_x;
    sav_pkg::sample_t               mean_accel_y;
    sav_pkg::sample_t               mean_accel_z;
    sav_pkg::sample_t               mean_gyro_x;
    sav_pkg::sample_t               mean_gyro_y;
    sav_pkg::sample_t               mean_gyro_z;
    int                             mismatch_count;
    int                             results_owed;
    int                             idle_cycles = 0;
    int                             samples_sent = 0;

    always #4 clk = ~clk;

    six_axis_moving_average_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .gyro_x       (gyro_x),
        .gyro_y       (gyro_y),
        .gyro_z       (gyro_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mean_accel_x (mean_accel_x),
        .mean_accel_y (mean_accel_y),
        .mean_accel_z (mean_accel_z),
        .mean_gyro_x  (mean_gyro_x),
        .mean_gyro_y  (mean_gyro_y),
        .mean_gyro_z  (mean_gyro_z)
    );

    moving_average_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .gyro_x         (gyro_x),
        .gyro_y         (gyro_y),
        .gyro_z         (gyro_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mean_accel_x   (mean_accel_x),
        .mean_accel_y   (mean_accel_y),
        .mean_accel_z   (mean_accel_z),
        .mean_gyro_x    (mean_gyro_x),
        .mean_gyro_y    (mean_gyro_y),
        .mean_gyro_z    (mean_gyro_z),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IdleLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [sav_pkg::SampleBits-1:0] corner_value(input int idx);
        case (idx % 9)
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'h0001;
            5: return 16'h5555;
            6: return 16'haaaa;
            7: return 16'h4000;
            default: return 16'hbfff;
        endcase
    endfunction

    function automatic axis_vec_t random_sample(input logic [sav_pkg::SampleBits-1:0] lean,
                                                input int odds);
        axis_vec_t s;
        if ($urandom_range(0, odds) == 0)
        begin
            for (int i = 0; i < sav_pkg::Axes; i++)
                s[i] = lean;
            return s;
        end
        for (int i = 0; i < sav_pkg::Axes; i++)
            case ($urandom_range(0, 9))
                0: s[i] = 16'h7fff;
                1: s[i] = 16'h8000;
                2: s[i] = sav_pkg::SampleBits'($urandom_range(0, 16) - 8);
                default: s[i] = sav_pkg::SampleBits'($urandom);
            endcase
        return s;
    endfunction

    task automatic offer_sample(input axis_vec_t s, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= s[0];
        accel_y  <= s[1];
        accel_z  <= s[2];
        gyro_x   <= s[3];
        gyro_y   <= s[4];
        gyro_z   <= s[5];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        samples_sent++;
    endtask

    task automatic wait_all_means();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
    endtask

    task automatic write_window(input logic [sav_pkg::WindowBits-1:0] len);
        wait_all_means();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : mean_receiver
        int  taken;
        int  gap;
        bit  quiet;
        taken = 0;
        quiet = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (taken % 50 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if (taken == HoldAt)
                gap = LongHold;
            else
                gap = quiet ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    initial
    begin : stimulus
        axis_vec_t                      s;
        int                             span;
        int                             count;
        int                             phase;
        bit                             quiet;
        logic [sav_pkg::SampleBits-1:0] lean;
        logic [sav_pkg::WindowBits-1:0] len;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window of ten, filled and wrapped with corner values
        for (int k = 0; k < 15; k++)
        begin
            for (int i = 0; i < sav_pkg::Axes; i++)
                s[i] = corner_value(k < 3 ? k : k + i);
            offer_sample(s, k % 3);
        end

        // zero length acts as a window of one
        write_window('0);
        for (int k = 0; k < 3; k++)
            offer_sample(random_sample(16'h8000, 4), 0);

        phase = 0;
        while (samples_sent < SampleGoal)
        begin
            case (phase)
                0: len = 7'd1;
                1: len = 7'd64;
                2: len = 7'd127;
                3: len = 7'd65;
                4: len = 7'd2;
                default: len = ($urandom_range(0, 3) != 0)
                               ? sav_pkg::WindowBits'($urandom_range(1, 16))
                               : sav_pkg::WindowBits'($urandom_range(0, 127));
            endcase
            write_window(len);
            if (len == '0)
                span = 1;
            else if (int'(len) > sav_pkg::MaxWindow)
                span = sav_pkg::MaxWindow;
            else
                span = int'(len);
            count = (span > 16) ? span + $urandom_range(2, 20) : 2 * span + $urandom_range(2, 16);
            lean = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < count && samples_sent < SampleGoal; k++)
            begin
                if (samples_sent == SampleGoal / 2)
                    wait_all_means();
                // a full window of one extreme drives the sums to their limit
                offer_sample(random_sample(lean,
                                           (phase == 1 && k < sav_pkg::MaxWindow) ? 0 : 4),
                             quiet ? 0 : $urandom_range(0, 8));
            end
            phase++;
        end

        wait_all_means();
        repeat (DrainTail) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
